### design/rv_alu_pkg.sv
package rv_alu_pkg;

   // Operation codes
   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_XOR    = 5'd2,
      OP_OR     = 5'd3,
      OP_AND    = 5'd4,
      OP_SLL    = 5'd5,
      OP_SRL    = 5'd6,
      OP_SRA    = 5'd7,
      OP_SLT    = 5'd8,
      OP_SLTU   = 5'd9,
      OP_MUL    = 5'd10,
      OP_MULH   = 5'd11,
      OP_MULHSU = 5'd12,
      OP_MULHU  = 5'd13,
      OP_DIV    = 5'd14,
      OP_DIVU   = 5'd15,
      OP_REM    = 5'd16,
      OP_REMU   = 5'd17
   } op_type;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned DIV_STAGES = XLEN;
   // input reg, decode/multiply, mul fixup, divider stages, output reg
   localparam int unsigned LATENCY    = DIV_STAGES + 4;

   localparam logic [XLEN-1:0] ALL_ONES   = '1;
   localparam logic [4:0]      SHIFT_MASK = 5'h1F;

   // One item in flight through the divider section
   typedef struct packed {
      logic            valid;
      op_type          mode;
      logic [XLEN-1:0] side;   // finished result, or operand a for div ops
      logic [XLEN-1:0] rem;    // partial remainder
      logic [XLEN-1:0] quo;    // dividend bits out, quotient bits in
      logic [XLEN-1:0] dvs;    // divisor magnitude
      logic            neg_q;
      logic            neg_r;
      logic            dz;
   } div_pkt_type;

endpackage

### design/rv32im_integer_alu.sv
// RV32IM integer ALU, fully pipelined. One item may be issued with start in
// every cycle; busy is high only during reset. Every operation, simple or
// not, passes through the same chain of registers (rsp_valid pulses for one
// cycle), so results come back in issue order. The chain is an input
// register, a decode/multiply stage, a multiply-high correction stage, a
// restoring divider unrolled into 32 register stages, one quotient bit per
// stage, and an output register.
// The receiver cannot stall and none is needed: the pipeline never backs up.
module rv32im_integer_alu
   import rv_alu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [4:0]        req_mode,
   input  logic [XLEN-1:0]   req_operand_a,
   input  logic [XLEN-1:0]   req_operand_b,
   output logic              rsp_valid,
   output logic [XLEN-1:0]   rsp_result
);

   // Stage 1: input register
   logic            s1_valid_ff;
   logic [4:0]      s1_mode_ff;
   logic [XLEN-1:0] s1_a_ff, s1_b_ff;

   // Stage 2: simple results, raw product, divider setup
   logic              s2_valid_ff;
   op_type            s2_mode_ff;
   logic [XLEN-1:0]   s2_a_ff, s2_b_ff, s2_simple_ff;
   logic [2*XLEN-1:0] s2_prod_ff;
   logic [XLEN-1:0]   s2_ma_ff, s2_mb_ff;
   logic              s2_negq_ff, s2_negr_ff, s2_dz_ff;

   logic [XLEN-1:0]   s2_simple_in;
   logic [4:0]        shamt;
   logic              is_sdiv;

   // Stage 3 plus divider stages
   div_pkt_type s3_in;
   div_pkt_type s3_ff;
   div_pkt_type dv_in [DIV_STAGES];
   div_pkt_type dv_ff [DIV_STAGES];

   logic            out_valid_ff;
   logic [XLEN-1:0] out_result_ff, out_result_in;
   div_pkt_type     fin;

   assign busy = reset;

   // Simple ALU ops
   assign shamt   = s1_b_ff[4:0] & SHIFT_MASK;
   assign is_sdiv = (s1_mode_ff == OP_DIV) || (s1_mode_ff == OP_REM);

   always_comb begin
      case (s1_mode_ff)
         OP_ADD:  s2_simple_in = s1_a_ff + s1_b_ff;
         OP_SUB:  s2_simple_in = s1_a_ff - s1_b_ff;
         OP_XOR:  s2_simple_in = s1_a_ff ^ s1_b_ff;
         OP_OR:   s2_simple_in = s1_a_ff | s1_b_ff;
         OP_AND:  s2_simple_in = s1_a_ff & s1_b_ff;
         OP_SLL:  s2_simple_in = s1_a_ff << shamt;
         OP_SRL:  s2_simple_in = s1_a_ff >> shamt;
         OP_SRA:  s2_simple_in = XLEN'($signed(s1_a_ff) >>> shamt);
         OP_SLT:  s2_simple_in = {{(XLEN-1){1'b0}},
                                  ($signed(s1_a_ff) < $signed(s1_b_ff))};
         OP_SLTU: s2_simple_in = {{(XLEN-1){1'b0}}, (s1_a_ff < s1_b_ff)};
         default: s2_simple_in = '0;
      endcase
   end

   // Multiply-high correction; div ops carry operand a for divide by zero
   always_comb begin
      s3_in       = '0;
      s3_in.valid = s2_valid_ff;
      s3_in.mode  = s2_mode_ff;
      s3_in.rem   = '0;
      s3_in.quo   = s2_ma_ff;
      s3_in.dvs   = s2_mb_ff;
      s3_in.neg_q = s2_negq_ff;
      s3_in.neg_r = s2_negr_ff;
      s3_in.dz    = s2_dz_ff;
      case (s2_mode_ff)
         OP_MUL:    s3_in.side = s2_prod_ff[XLEN-1:0];
         OP_MULHU:  s3_in.side = s2_prod_ff[2*XLEN-1:XLEN];
         OP_MULHSU: s3_in.side = s2_prod_ff[2*XLEN-1:XLEN]
                                 - (s2_a_ff[XLEN-1] ? s2_b_ff : '0);
         OP_MULH:   s3_in.side = s2_prod_ff[2*XLEN-1:XLEN]
                                 - (s2_a_ff[XLEN-1] ? s2_b_ff : '0)
                                 - (s2_b_ff[XLEN-1] ? s2_a_ff : '0);
         OP_DIV, OP_DIVU, OP_REM, OP_REMU: s3_in.side = s2_a_ff;
         default:   s3_in.side = s2_simple_ff;
      endcase
   end

   // Restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      div_pkt_type      src;
      logic [XLEN:0]    shifted;
      logic [XLEN+1:0]  diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign src = s3_ff;
      end else begin : g_next
         assign src = dv_ff[k-1];
      end

      assign shifted = {src.rem, src.quo[XLEN-1]};
      assign diff    = {1'b0, shifted} - {2'b00, src.dvs};
      assign ge      = ~diff[XLEN+1];

      always_comb begin
         dv_in[k]     = src;
         dv_in[k].rem = ge ? diff[XLEN-1:0] : shifted[XLEN-1:0];
         dv_in[k].quo = {src.quo[XLEN-2:0], ge};
      end
   end

   // Final sign fix and special cases
   assign fin = dv_ff[DIV_STAGES-1];

   always_comb begin
      case (fin.mode)
         OP_DIV, OP_DIVU:
            out_result_in = fin.dz ? ALL_ONES : (fin.neg_q ? (XLEN'(0) - fin.quo) : fin.quo);
         OP_REM, OP_REMU:
            out_result_in = fin.dz ? fin.side : (fin.neg_r ? (XLEN'(0) - fin.rem) : fin.rem);
         default:
            out_result_in = fin.side;
      endcase
   end

   // Pipeline registers; valid bits and divider packets are cleared on reset
   always_ff @(posedge clock) begin
      s1_mode_ff   <= req_mode;
      s1_a_ff      <= req_operand_a;
      s1_b_ff      <= req_operand_b;

      s2_mode_ff   <= op_type'(s1_mode_ff);
      s2_a_ff      <= s1_a_ff;
      s2_b_ff      <= s1_b_ff;
      s2_simple_ff <= s2_simple_in;
      s2_prod_ff   <= s1_a_ff * s1_b_ff;
      s2_ma_ff     <= (is_sdiv && s1_a_ff[XLEN-1]) ? (XLEN'(0) - s1_a_ff) : s1_a_ff;
      s2_mb_ff     <= (is_sdiv && s1_b_ff[XLEN-1]) ? (XLEN'(0) - s1_b_ff) : s1_b_ff;
      s2_negq_ff   <= is_sdiv && (s1_a_ff[XLEN-1] ^ s1_b_ff[XLEN-1]);
      s2_negr_ff   <= is_sdiv && s1_a_ff[XLEN-1];
      s2_dz_ff     <= (s1_b_ff == '0);

      out_result_ff <= out_result_in;

      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_ff        <= '0;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_ff[k] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_ff        <= s3_in;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_valid_ff <= fin.valid;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;

   // Every result traces back to an earlier issued item
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching issue");

   // Divider invariant: partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && !fin.dz && (fin.mode == OP_DIV || fin.mode == OP_DIVU ||
       fin.mode == OP_REM || fin.mode == OP_REMU)) |-> (fin.rem < fin.dvs))
      else $error("divider remainder out of range");

   // Set-less-than results are a single bit
   a_slt_bit: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && (fin.mode == OP_SLT || fin.mode == OP_SLTU))
      |=> (rsp_valid && rsp_result[XLEN-1:1] == '0))
      else $error("set-less-than result wider than one bit");

endmodule
